// ----- rtl/tds_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Task dependency scheduler package
// Shared types, codes and command/status bundles for the scheduler.
// ----------------------------------------------------------------------------
package tds_pkg;

  localparam int DEF_MAX_NODES      = 16;
  localparam int DEF_MAX_SUCCESSORS = 4;

  localparam int ID_W       = 4;
  localparam int DEPC_W     = 7;
  localparam int RESULT_CAP = 16;
  localparam int NRES_W     = $clog2(RESULT_CAP + 1);

  localparam logic [DEPC_W-1:0] COUNT_MAX = DEPC_W'(127);

  typedef enum logic [2:0] {
    OP_ADD_NODE = 3'd0,
    OP_ADD_EDGE = 3'd1,
    OP_START    = 3'd2,
    OP_FINISH   = 3'd3,
    OP_ABORT    = 3'd4,
    OP_SUSPEND  = 3'd5,
    OP_RESUME   = 3'd6
  } opcode_t;

  typedef enum logic [2:0] {
    K_ACK    = 3'd0,
    K_POOL   = 3'd1,
    K_HOST   = 3'd2,
    K_ABORT  = 3'd3,
    K_DONE   = 3'd4,
    K_REJECT = 3'd5,
    K_EMPTY  = 3'd6
  } kind_t;

  typedef struct packed {
    opcode_t           opcode;
    logic [ID_W-1:0]   node_a;
    logic [ID_W-1:0]   node_b;
    logic              has_host;
  } tds_in_t;

  typedef struct packed {
    kind_t             kind;
    logic [ID_W-1:0]   node_id;
    logic              last;
  } tds_out_t;

  // Address source for the node table read port.
  typedef enum logic [1:0] {
    RS_A    = 2'd0,
    RS_B    = 2'd1,
    RS_WALK = 2'd2,
    RS_SUCC = 2'd3
  } rd_sel_t;

  // Source of the node id in an emitted result.
  typedef enum logic [1:0] {
    ID_A    = 2'd0,
    ID_ZERO = 2'd1,
    ID_NT   = 2'd2,
    ID_RD   = 2'd3
  } id_sel_t;

  typedef enum logic [1:0] {
    PEND_LOAD = 2'd0,
    PEND_DEC  = 2'd1,
    PEND_INC  = 2'd2
  } pend_op_t;

  typedef struct packed {
    logic     load_in;
    logic     rd_en;
    rd_sel_t  rd_sel;
    logic     succ_rd;
    logic     save_a;
    logic     wr_node;
    logic     wr_edge;
    logic     wr_pend;
    pend_op_t pend_op;
    logic     cnt_clr;
    logic     cnt_inc;
    logic     nt_inc;
    logic     fin_clr;
    logic     fin_inc;
    logic     run_set;
    logic     run_clr;
    logic     emit;
    logic     emit_ready;
    kind_t    emit_kind;
    id_sel_t  id_sel;
    logic     flush;
  } tds_cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    running;
    logic    full;
    logic    a_ok;
    logic    b_ok;
    logic    edge_ok;
    logic    pend_zero;
    logic    pend_one;
    logic    dep_zero;
    logic    walk_done;
    logic    succ_done;
    logic    fin_last;
    logic    n_zero;
    logic    out_free;
  } tds_sts_t;

endpackage

// ----- rtl/tds_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Task dependency scheduler controller
// Sequences each operation over the datapath through commands and status.
// ----------------------------------------------------------------------------
module tds_ctrl
  import tds_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  tds_sts_t sts,
  output tds_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_EDGE_RB,
    S_EDGE_CHK,
    S_ST_RD,
    S_ST_WR,
    S_FR_SAVE,
    S_FS_RD,
    S_FS_REC,
    S_FS_UPD,
    S_FIN_TAIL,
    S_SR,
    S_END,
    S_FLUSH
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.rd_sel    = RS_A;
    cmd.pend_op   = PEND_LOAD;
    cmd.emit_kind = K_ACK;
    cmd.id_sel    = ID_A;
    in_ready      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
        if (in_valid) begin
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        if (sts.out_free) begin
          unique case (sts.op) inside
            OP_ADD_NODE: begin
              cmd.emit = 1'b1;
              if (sts.running || sts.full) begin
                cmd.emit_kind = K_REJECT;
                cmd.id_sel    = ID_A;
              end else begin
                cmd.wr_node   = 1'b1;
                cmd.nt_inc    = 1'b1;
                cmd.emit_kind = K_ACK;
                cmd.id_sel    = ID_NT;
              end
              state_nxt = S_FLUSH;
            end
            OP_ADD_EDGE: begin
              if (sts.running || !sts.a_ok || !sts.b_ok) begin
                cmd.emit      = 1'b1;
                cmd.emit_kind = K_REJECT;
                cmd.id_sel    = ID_A;
                state_nxt     = S_FLUSH;
              end else begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RS_A;
                state_nxt  = S_EDGE_RB;
              end
            end
            OP_START: begin
              if (sts.running) begin
                cmd.emit      = 1'b1;
                cmd.emit_kind = K_REJECT;
                cmd.id_sel    = ID_ZERO;
                state_nxt     = S_FLUSH;
              end else begin
                cmd.fin_clr = 1'b1;
                cmd.cnt_clr = 1'b1;
                state_nxt   = S_ST_RD;
              end
            end
            OP_FINISH, OP_ABORT: begin
              if (!sts.running || !sts.a_ok) begin
                cmd.emit      = 1'b1;
                cmd.emit_kind = K_REJECT;
                cmd.id_sel    = ID_A;
                state_nxt     = S_FLUSH;
              end else begin
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = RS_A;
                cmd.cnt_clr = 1'b1;
                state_nxt   = S_FR_SAVE;
              end
            end
            OP_SUSPEND, OP_RESUME: begin
              if (!sts.running || !sts.a_ok) begin
                cmd.emit      = 1'b1;
                cmd.emit_kind = K_REJECT;
                cmd.id_sel    = ID_A;
                state_nxt     = S_FLUSH;
              end else begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RS_A;
                state_nxt  = S_SR;
              end
            end
            default: begin
              cmd.emit      = 1'b1;
              cmd.emit_kind = K_REJECT;
              cmd.id_sel    = ID_ZERO;
              state_nxt     = S_FLUSH;
            end
          endcase
        end
      end

      S_EDGE_RB: begin
        cmd.save_a = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RS_B;
        state_nxt  = S_EDGE_CHK;
      end

      S_EDGE_CHK: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          cmd.id_sel = ID_A;
          if (sts.edge_ok) begin
            cmd.wr_edge   = 1'b1;
            cmd.emit_kind = K_ACK;
          end else begin
            cmd.emit_kind = K_REJECT;
          end
          state_nxt = S_FLUSH;
        end
      end

      S_ST_RD: begin
        if (sts.walk_done) begin
          state_nxt = S_END;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RS_WALK;
          state_nxt  = S_ST_WR;
        end
      end

      S_ST_WR: begin
        if (!sts.dep_zero || sts.out_free) begin
          cmd.wr_pend    = 1'b1;
          cmd.pend_op    = PEND_LOAD;
          cmd.cnt_inc    = 1'b1;
          cmd.emit       = sts.dep_zero;
          cmd.emit_ready = 1'b1;
          cmd.id_sel     = ID_RD;
          state_nxt      = S_ST_RD;
        end
      end

      S_FR_SAVE: begin
        cmd.save_a = 1'b1;
        state_nxt  = S_FS_RD;
      end

      S_FS_RD: begin
        if (sts.succ_done) begin
          state_nxt = S_FIN_TAIL;
        end else begin
          cmd.succ_rd = 1'b1;
          state_nxt   = S_FS_REC;
        end
      end

      S_FS_REC: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RS_SUCC;
        state_nxt  = S_FS_UPD;
      end

      S_FS_UPD: begin
        if (!sts.pend_one || sts.out_free) begin
          cmd.wr_pend    = !sts.pend_zero;
          cmd.pend_op    = PEND_DEC;
          cmd.emit       = sts.pend_one;
          cmd.emit_ready = (sts.op != OP_ABORT);
          cmd.emit_kind  = K_ABORT;
          cmd.id_sel     = ID_RD;
          cmd.cnt_inc    = 1'b1;
          state_nxt      = S_FS_RD;
        end
      end

      S_FIN_TAIL: begin
        if (sts.fin_last) begin
          if (sts.out_free) begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = K_DONE;
            cmd.id_sel    = ID_A;
            cmd.fin_clr   = 1'b1;
            cmd.run_clr   = 1'b1;
            state_nxt     = S_END;
          end
        end else begin
          cmd.fin_inc = 1'b1;
          state_nxt   = S_END;
        end
      end

      S_SR: begin
        if (sts.op == OP_SUSPEND) begin
          cmd.wr_pend = 1'b1;
          cmd.pend_op = PEND_INC;
          state_nxt   = S_END;
        end else if (!sts.pend_one || sts.out_free) begin
          cmd.wr_pend    = !sts.pend_zero;
          cmd.pend_op    = PEND_DEC;
          cmd.emit       = sts.pend_one;
          cmd.emit_ready = 1'b1;
          cmd.id_sel     = ID_RD;
          state_nxt      = S_END;
        end
      end

      S_END: begin
        if (!sts.n_zero) begin
          cmd.run_set = (sts.op == OP_START);
          state_nxt   = S_FLUSH;
        end else if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.op == OP_START) begin
            cmd.emit_kind = K_EMPTY;
            cmd.id_sel    = ID_ZERO;
          end else begin
            cmd.emit_kind = K_ACK;
            cmd.id_sel    = ID_A;
          end
          state_nxt = S_FLUSH;
        end
      end

      S_FLUSH: begin
        if (sts.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/tds_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Task dependency scheduler datapath
// Node table, successor memory, run counters and the result staging.
// ----------------------------------------------------------------------------
module tds_dpath
  import tds_pkg::*;
#(
  parameter int MAX_NODES      = DEF_MAX_NODES,
  parameter int MAX_SUCCESSORS = DEF_MAX_SUCCESSORS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  tds_in_t  in_item,
  input  tds_cmd_t cmd,
  output tds_sts_t sts,
  input  logic     out_ready,
  output logic     out_valid,
  output tds_out_t out_item
);

  localparam int NW     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW     = $clog2(MAX_NODES + 1);
  localparam int SCW    = $clog2(MAX_SUCCESSORS + 1);
  localparam int SDEPTH = MAX_NODES * MAX_SUCCESSORS;
  localparam int SAW    = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
  localparam int CNTW   = (CW > SCW) ? CW : SCW;
  localparam int CMPW   = (CW > ID_W) ? CW : ID_W;

  // Node table and successor lists. Every entry is written by add node or
  // add edge before it can be read, so none of them needs a reset.
  logic              host_mem [MAX_NODES];
  logic [DEPC_W-1:0] dep_mem  [MAX_NODES];
  logic [DEPC_W-1:0] pend_mem [MAX_NODES];
  logic [SCW-1:0]    scnt_mem [MAX_NODES];
  logic [NW-1:0]     succ_mem [SDEPTH];

  opcode_t           op_r;
  logic [ID_W-1:0]   a_r, b_r;
  logic              h_r;

  logic [CW-1:0]     node_total_r;
  logic              running_r;
  logic [CW-1:0]     fin_r;
  logic [CNTW-1:0]   cnt_r;
  logic [SCW-1:0]    sa_r;
  logic [NRES_W-1:0] n_r;

  logic              rd_host_r;
  logic [DEPC_W-1:0] rd_dep_r, rd_pend_r;
  logic [SCW-1:0]    rd_scnt_r;
  logic [NW-1:0]     rd_addr_r;
  logic [NW-1:0]     succ_rd_r;

  logic              held_v_r;
  tds_out_t          held_r;
  logic              out_valid_r;
  tds_out_t          out_r;

  logic [NW-1:0]     a_idx, b_idx, nt_idx, rd_addr;
  logic [SAW-1:0]    a_base, succ_raddr, succ_waddr;
  logic [DEPC_W-1:0] pend_nxt;
  logic [CW-1:0]     fin_nxt;
  logic              out_free, emit_take, push_held;
  kind_t             new_kind;
  logic [ID_W-1:0]   new_id;

  assign a_idx      = NW'(a_r);
  assign b_idx      = NW'(b_r);
  assign nt_idx     = NW'(node_total_r);
  assign a_base     = SAW'(a_idx) * SAW'(MAX_SUCCESSORS);
  assign succ_raddr = a_base + SAW'(cnt_r);
  assign succ_waddr = a_base + SAW'(sa_r);
  assign fin_nxt    = fin_r + CW'(1);

  always_comb begin
    case (cmd.rd_sel)
      RS_A:    rd_addr = a_idx;
      RS_B:    rd_addr = b_idx;
      RS_WALK: rd_addr = NW'(cnt_r);
      default: rd_addr = succ_rd_r;
    endcase
  end

  always_comb begin
    case (cmd.pend_op)
      PEND_LOAD: pend_nxt = rd_dep_r;
      PEND_DEC:  pend_nxt = rd_pend_r - DEPC_W'(1);
      PEND_INC:  pend_nxt = (rd_pend_r == COUNT_MAX) ? rd_pend_r : rd_pend_r + DEPC_W'(1);
      default:   pend_nxt = rd_pend_r;
    endcase
  end

  always_comb begin
    case (cmd.id_sel)
      ID_A:    new_id = a_r;
      ID_ZERO: new_id = '0;
      ID_NT:   new_id = ID_W'(node_total_r);
      default: new_id = ID_W'(rd_addr_r);
    endcase
  end

  assign new_kind  = cmd.emit_ready ? (rd_host_r ? K_HOST : K_POOL) : cmd.emit_kind;
  assign out_free  = !out_valid_r || out_ready;
  assign emit_take = cmd.emit && (n_r < NRES_W'(RESULT_CAP));
  assign push_held = (emit_take && held_v_r) || cmd.flush;

  always_comb begin
    sts           = '0;
    sts.op        = op_r;
    sts.running   = running_r;
    sts.full      = (node_total_r >= CW'(MAX_NODES));
    sts.a_ok      = (CMPW'(a_r) < CMPW'(node_total_r));
    sts.b_ok      = (CMPW'(b_r) < CMPW'(node_total_r));
    sts.edge_ok   = (sa_r < SCW'(MAX_SUCCESSORS)) && (rd_dep_r < COUNT_MAX);
    sts.pend_zero = (rd_pend_r == '0);
    sts.pend_one  = (rd_pend_r == DEPC_W'(1));
    sts.dep_zero  = (rd_dep_r == '0);
    sts.walk_done = (cnt_r == CNTW'(node_total_r));
    sts.succ_done = (cnt_r == CNTW'(sa_r));
    sts.fin_last  = (fin_nxt == node_total_r);
    sts.n_zero    = (n_r == '0);
    sts.out_free  = out_free;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_total_r <= '0;
      running_r    <= 1'b0;
      fin_r        <= '0;
      cnt_r        <= '0;
      n_r          <= '0;
      held_v_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.nt_inc) begin
        node_total_r <= node_total_r + CW'(1);
      end
      if (cmd.run_set) begin
        running_r <= 1'b1;
      end else if (cmd.run_clr) begin
        running_r <= 1'b0;
      end
      if (cmd.fin_clr) begin
        fin_r <= '0;
      end else if (cmd.fin_inc) begin
        fin_r <= fin_nxt;
      end
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + CNTW'(1);
      end
      if (cmd.load_in) begin
        n_r <= '0;
      end else if (emit_take) begin
        n_r <= n_r + NRES_W'(1);
      end
      if (emit_take) begin
        held_v_r <= 1'b1;
      end else if (cmd.flush) begin
        held_v_r <= 1'b0;
      end
      if (push_held) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload, table and memory updates.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r <= in_item.opcode;
      a_r  <= in_item.node_a;
      b_r  <= in_item.node_b;
      h_r  <= in_item.has_host;
    end
    if (cmd.wr_node) begin
      host_mem[nt_idx] <= h_r;
      dep_mem[nt_idx]  <= '0;
      pend_mem[nt_idx] <= '0;
      scnt_mem[nt_idx] <= '0;
    end
    if (cmd.wr_edge) begin
      succ_mem[succ_waddr] <= b_idx;
      scnt_mem[a_idx]      <= sa_r + SCW'(1);
      dep_mem[b_idx]       <= rd_dep_r + DEPC_W'(1);
    end
    if (cmd.wr_pend) begin
      pend_mem[rd_addr_r] <= pend_nxt;
    end
    if (cmd.rd_en) begin
      rd_host_r <= host_mem[rd_addr];
      rd_dep_r  <= dep_mem[rd_addr];
      rd_pend_r <= pend_mem[rd_addr];
      rd_scnt_r <= scnt_mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
    if (cmd.succ_rd) begin
      succ_rd_r <= succ_mem[succ_raddr];
    end
    if (cmd.save_a) begin
      sa_r <= rd_scnt_r;
    end
    if (emit_take) begin
      held_r.kind    <= new_kind;
      held_r.node_id <= new_id;
      held_r.last    <= 1'b0;
    end
    if (push_held) begin
      out_r.kind    <= held_r.kind;
      out_r.node_id <= held_r.node_id;
      out_r.last    <= cmd.flush;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_flush_held: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |-> held_v_r)
    else $error("flush with no staged result");

  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    push_held |-> out_free)
    else $error("output register overwritten while occupied");

  a_load_clean: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_in |-> !held_v_r)
    else $error("new operation taken with a staged result left over");

  a_run_count: assert property (@(posedge clk) disable iff (!rst_n)
    running_r |-> (node_total_r != '0) && (fin_r < node_total_r))
    else $error("completion count out of range while running");

  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= NRES_W'(RESULT_CAP))
    else $error("result count above cap");

endmodule

// ----- rtl/task_dependency_scheduler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Task dependency scheduler
// Dependency-counting dataflow scheduler for a small task graph.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake              Payload
//  in_      input      in_valid / in_ready    tds_in_t  (opcode, node_a, node_b, has_host)
//  out_     output     out_valid / out_ready  tds_out_t (kind, node_id, last)
//
//  One operation is in flight at a time; in_ready is high only while the controller is idle.
//  Start reads and writes the node table once per node. Finish and abort read the successor
//  memory, read the node table and write the pending count for each successor in turn.
//  Reset is synchronous and needs no clearing pass. While the output register is full and
//  out_ready is low, decode and every step that emits or closes a result wait.
//
// The block stores a task graph: per node a host flag, a dependency total, a
// pending count and a successor list. Start reloads every pending count from
// its total and reports the nodes that have no dependencies. Finishing a node
// decrements its successors and reports those that become ready, to the pool
// or to the host queue; abort reports them as abort successors instead. When
// the number of retired nodes reaches the node total, graph done is reported
// and the graph stops running.
//
// The controller is a single state machine; the datapath holds the node
// table, the successor memory, the run counters and the result staging. Each
// result is first held in a staging register and only moved to the output
// register when the next one arrives, or when the operation ends, so that the
// final result of an operation can carry the last flag. No more than sixteen
// results are reported for one operation; further ones are dropped.
//
// The output register sits between the datapath and the out_ channel, so a
// new transfer can be taken on the in_ channel while the last result of the
// previous operation is still waiting to be taken.
// ----------------------------------------------------------------------------
module task_dependency_scheduler
  import tds_pkg::*;
#(
  parameter int MAX_NODES      = DEF_MAX_NODES,
  parameter int MAX_SUCCESSORS = DEF_MAX_SUCCESSORS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  tds_in_t  in_item,
  output logic     out_valid,
  input  logic     out_ready,
  output tds_out_t out_item
);

  tds_cmd_t cmd;
  tds_sts_t sts;

  // Controller: decodes the operation and walks the node table or the
  // successor list one step at a time.
  tds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: storage, counters and the two-deep result staging that feeds
  // the out_ channel.
  tds_dpath #(
    .MAX_NODES      (MAX_NODES),
    .MAX_SUCCESSORS (MAX_SUCCESSORS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
